FILE: hw/rtl/wsqs_pkg.sv
// ----------------------------------------------------------------------------
// wsqs_pkg
// Shared types and constants for the windowed signal quality scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsqs_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned Q16_W   = 17;   // Q0.16 value that can reach 1.0
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned CFG_NUM = 8;
	localparam int unsigned DIV_W   = 32;

	// register indexes
	localparam logic [2:0] REG_RANGE_GOOD    = 3'd0;
	localparam logic [2:0] REG_RANGE_BAD     = 3'd1;
	localparam logic [2:0] REG_SPREAD_GOOD   = 3'd2;
	localparam logic [2:0] REG_SPREAD_BAD    = 3'd3;
	localparam logic [2:0] REG_CALM_RANGE    = 3'd4;
	localparam logic [2:0] REG_SETTLING_LOW  = 3'd5;
	localparam logic [2:0] REG_SETTLING_HIGH = 3'd6;
	localparam logic [2:0] REG_SETTLED_LOW   = 3'd7;

	// reason codes
	localparam logic [1:0] REASON_DISC     = 2'd0;
	localparam logic [1:0] REASON_WARMING  = 2'd1;
	localparam logic [1:0] REASON_UNSTABLE = 2'd2;
	localparam logic [1:0] REASON_STABLE   = 2'd3;

	localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

	// divider jobs, in the order they run
	typedef enum logic [1:0] {
		JOB_SPREAD = 2'd0,
		JOB_RANGE  = 2'd1,
		JOB_SPR    = 2'd2,
		JOB_RATIO  = 2'd3
	} job_t;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_WALK  = 11'b00000000010,
		ST_MULA  = 11'b00000000100,
		ST_MULB  = 11'b00000001000,
		ST_VSUB  = 11'b00000010000,
		ST_SQRT  = 11'b00000100000,
		ST_DSET  = 11'b00001000000,
		ST_DIV   = 11'b00010000000,
		ST_DDONE = 11'b00100000000,
		ST_BAND  = 11'b01000000000,
		ST_FIN   = 11'b10000000000
	} state_t;

	function automatic logic [DATA_W-1:0] cfg_reset_value(input logic [2:0] idx);
		logic [DATA_W-1:0] v;
		case (idx)
			REG_RANGE_GOOD:    v = 16'd64;
			REG_RANGE_BAD:     v = 16'd154;
			REG_SPREAD_GOOD:   v = 16'd26;
			REG_SPREAD_BAD:    v = 16'd51;
			REG_CALM_RANGE:    v = 16'd102;
			REG_SETTLING_LOW:  v = 16'd19661;
			REG_SETTLING_HIGH: v = 16'd39322;
			REG_SETTLED_LOW:   v = 16'd45875;
			default:           v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wsqs_if.sv
// ----------------------------------------------------------------------------
// wsqs_if
// Valid/ready channels for sample items and score items.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsqs_meas_if;
	logic               valid;
	logic               ready;
	logic               contact_ok;
	logic signed [15:0] sample;

	modport source(output valid, output contact_ok, output sample, input ready);
	modport sink(input valid, input contact_ok, input sample, output ready);
endinterface

interface wsqs_score_if;
	logic        valid;
	logic        ready;
	logic        quality_ok;
	logic [15:0] quality;
	logic [1:0]  reason;
	logic [15:0] window_range;
	logic [15:0] window_spread;

	modport source(output valid, output quality_ok, output quality, output reason,
		output window_range, output window_spread, input ready);
	modport sink(input valid, input quality_ok, input quality, input reason,
		input window_range, input window_spread, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/windowed_signal_quality_scorer_unit.sv
// ----------------------------------------------------------------------------
// windowed_signal_quality_scorer_unit
// Window range / std-dev scorer with unstable latch and Q0.16 quality blend.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+---------------------------------------------
//  meas    | in  | valid/ready    | contact_ok, sample (s16, 1/256 degC)
//  score   | out | valid/ready    | quality_ok, quality, reason, range, spread
//  apb     | in  | psel/penable   | 8 x 16-bit registers at 4*i, pready tied 1
//
//  One item at a time. A connected item walks the n filled window entries,
//  takes an RW-bit square root (22 root bits at the default window) and runs
//  the 32-step shared divider up to four times; the range and spread ramps skip
//  it when their score is fixed. A disconnected item goes straight to the final step.
//  meas.ready is high only in idle. A finished result waits in the output
//  register; a stalled score channel holds the sequencer at its last step.
//  Reset is asynchronous; the sample ring is not cleared (only written slots
//  are ever read).
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_signal_quality_scorer_unit #(
	parameter int unsigned WINDOW_LEN      = 32,
	parameter int unsigned WARMUP_TICKS    = 64,
	parameter int unsigned FULL_TICKS      = 256,
	parameter int unsigned CALM_HOLD_TICKS = 8,
	parameter int unsigned SETTLED_TOP     = 65535
) (
	input  wire                             clk,
	input  wire                             arst_n,
	wsqs_meas_if.sink                       meas,
	wsqs_score_if.source                    score,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire  [wsqs_pkg::PADDR_W-1:0]    paddr,
	input  wire  [wsqs_pkg::PDATA_W-1:0]    pwdata,
	output logic [wsqs_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import wsqs_pkg::*;

	// window geometry
	localparam int unsigned AW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int unsigned NW   = $clog2(WINDOW_LEN + 1);
	localparam int unsigned SUMW = DATA_W + NW;            // signed sum
	localparam int unsigned SQW  = 31 + NW;                // sum of squares
	localparam int unsigned VARW = SQW + NW;               // n * sumsq
	localparam int unsigned XW   = VARW + (VARW % 2);
	localparam int unsigned RW   = XW / 2;                 // root bits
	localparam int unsigned RCW  = $clog2(RW);
	localparam int unsigned REMW = RW + 3;

	localparam logic [AW-1:0]     SLOT_LAST = AW'(WINDOW_LEN - 1);
	localparam logic [NW-1:0]     FILL_MAX  = NW'(WINDOW_LEN);
	localparam logic [DATA_W-1:0] WARM16    = DATA_W'(WARMUP_TICKS);
	localparam logic [DATA_W-1:0] FULL16    = DATA_W'(FULL_TICKS);
	localparam logic [7:0]        CALM8     = 8'(CALM_HOLD_TICKS);
	localparam logic [DATA_W-1:0] TOP16     = DATA_W'(SETTLED_TOP);

	// ---------------- configuration ----------------
	logic [DATA_W-1:0] cfg_q [CFG_NUM];
	logic              cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = PDATA_W'(cfg_q[paddr[4:2]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) begin
				cfg_q[i] <= cfg_reset_value(3'(i));
			end
		end else if (cfg_wr) begin
			cfg_q[paddr[4:2]] <= pwdata[DATA_W-1:0];
		end
	end

	// ---------------- state ----------------
	state_t            st_q;
	job_t              job_q;
	logic [AW-1:0]     slot_q;
	logic [NW-1:0]     fill_q;
	logic [DATA_W-1:0] vrun_q;
	logic              unstable_q;
	logic [7:0]        calm_q;
	logic              disc_q;

	// walk
	logic [NW-1:0]            ic_q;
	logic                     vld_s1, vld_s2;
	logic signed [DATA_W-1:0] rd_s1, val_s2;
	logic [31:0]              sq_s2;
	logic                     first_q;
	logic signed [DATA_W-1:0] mn_q, mx_q;
	logic signed [SUMW-1:0]   sum_q;
	logic [SQW-1:0]           sumsq_q;
	logic [VARW-1:0]          prod1_q;
	logic [2*SUMW-1:0]        prod2_q;

	// root
	logic [XW-1:0]   x_q;
	logic [REMW-1:0] rem_q;
	logic [RW-1:0]   root_q;
	logic [RCW-1:0]  rcnt_q;

	// divider (num_q turns into the quotient)
	logic [DIV_W-1:0]  num_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] drem_q;
	logic [4:0]        dcnt_q;

	// scores and blend
	logic [DATA_W-1:0] range_q, spread_q;
	logic [Q16_W-1:0]  s1_q, s2_q, blend_q;
	logic              warm_q;
	logic [32:0]       bprod_q;

	// output register
	logic              ovalid_q, ook_q;
	logic [DATA_W-1:0] oq_q, orng_q, ospr_q;
	logic [1:0]        orsn_q;

	// ---------------- sample ring ----------------
	logic signed [DATA_W-1:0] ring [WINDOW_LEN];
	logic                     acc, ring_wr;
	assign acc     = meas.valid && meas.ready;
	assign ring_wr = acc && meas.contact_ok;

	always_ff @(posedge clk) begin
		if (ring_wr) begin
			ring[slot_q] <= meas.sample;
		end
		rd_s1 <= ring[ic_q[AW-1:0]];
	end

	// ---------------- combinational helpers ----------------
	logic [REMW+1:0] rem_n, trial;
	logic [DATA_W:0] dr_n;
	logic [Q16_W-1:0] stab, ratio;
	logic [DATA_W-1:0] band_lo, band_hi, band_diff, range_w, vrun_n;
	logic              band_up, high;
	logic [7:0]        calm_n;
	logic [Q16_W:0]    blend_sum;   // both terms can reach 1.0

	assign rem_n = {rem_q, x_q[XW-1 -: 2]};
	assign trial = (REMW+2)'({root_q, 2'b01});
	assign dr_n  = {drem_q, num_q[DIV_W-1]};
	assign stab  = (s1_q < s2_q) ? s1_q : s2_q;
	assign ratio = (num_q > DIV_W'(ONE_Q16)) ? ONE_Q16 : num_q[Q16_W-1:0];
	assign blend_sum = (Q16_W+1)'(ratio) + (Q16_W+1)'(stab);
	assign range_w = DATA_W'(mx_q - mn_q);
	assign vrun_n  = (vrun_q == '1) ? vrun_q : vrun_q + 1'b1;
	assign high    = (range_q > cfg_q[REG_RANGE_BAD]) || (spread_q > cfg_q[REG_SPREAD_BAD]);
	assign calm_n  = calm_q + 1'b1;

	assign band_lo   = warm_q ? cfg_q[REG_SETTLING_LOW] : cfg_q[REG_SETTLED_LOW];
	assign band_hi   = warm_q ? cfg_q[REG_SETTLING_HIGH] : TOP16;
	assign band_up   = band_hi >= band_lo;
	assign band_diff = band_up ? band_hi - band_lo : band_lo - band_hi;

	// ramp setup: selects the measure and its good and bad thresholds for the range or spread job
	logic [DATA_W-1:0] rmp_m, rmp_good, rmp_bad;
	always_comb begin
		if (job_q == JOB_RANGE) begin
			rmp_m    = range_q;
			rmp_good = cfg_q[REG_RANGE_GOOD];
			rmp_bad  = cfg_q[REG_RANGE_BAD];
		end else begin
			rmp_m    = spread_q;
			rmp_good = cfg_q[REG_SPREAD_GOOD];
			rmp_bad  = cfg_q[REG_SPREAD_BAD];
		end
	end

	// ---------------- sequencer ----------------
	assign meas.ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			job_q      <= JOB_SPREAD;
			slot_q     <= '0;
			fill_q     <= '0;
			vrun_q     <= '0;
			unstable_q <= 1'b0;
			calm_q     <= '0;
			disc_q     <= 1'b0;
			ic_q       <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			first_q    <= 1'b1;
			ovalid_q   <= 1'b0;
		end else begin
			// the final step reloads the output register itself
			if (ovalid_q && score.ready && st_q != ST_FIN) begin
				ovalid_q <= 1'b0;
			end

			// walk pipeline: read -> square -> accumulate
			vld_s1 <= (st_q == ST_WALK) && (ic_q < fill_q);
			vld_s2 <= vld_s1;
			sq_s2  <= $unsigned(32'(rd_s1) * 32'(rd_s1));
			val_s2 <= rd_s1;
			if (vld_s2) begin
				first_q <= 1'b0;
				if (first_q || val_s2 < mn_q) mn_q <= val_s2;
				if (first_q || val_s2 > mx_q) mx_q <= val_s2;
				sum_q   <= sum_q + SUMW'(val_s2);
				sumsq_q <= sumsq_q + SQW'(sq_s2);
			end

			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						if (!meas.contact_ok) begin
							slot_q     <= '0;
							fill_q     <= '0;
							vrun_q     <= '0;
							unstable_q <= 1'b0;
							calm_q     <= '0;
							disc_q     <= 1'b1;
							st_q       <= ST_FIN;
						end else begin
							slot_q  <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
							if (fill_q < FILL_MAX) fill_q <= fill_q + 1'b1;
							vrun_q  <= vrun_n;
							disc_q  <= 1'b0;
							ic_q    <= '0;
							first_q <= 1'b1;
							sum_q   <= '0;
							sumsq_q <= '0;
							st_q    <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (ic_q < fill_q) begin
						ic_q <= ic_q + 1'b1;
					end else if (!vld_s1 && !vld_s2) begin
						st_q <= ST_MULA;
					end
				end
				ST_MULA: begin
					prod1_q <= VARW'(fill_q) * sumsq_q;
					range_q <= range_w;
					st_q    <= ST_MULB;
				end
				ST_MULB: begin
					prod2_q <= (2*SUMW)'(sum_q < 0 ? -sum_q : sum_q) *
						(2*SUMW)'(sum_q < 0 ? -sum_q : sum_q);
					st_q    <= ST_VSUB;
				end
				ST_VSUB: begin
					x_q    <= XW'(VARW'((2*SUMW)'(prod1_q) - prod2_q));
					rem_q  <= '0;
					root_q <= '0;
					rcnt_q <= RCW'(RW - 1);
					st_q   <= ST_SQRT;
				end
				ST_SQRT: begin
					// one root digit per cycle
					x_q <= x_q << 2;
					if (rem_n >= trial) begin
						rem_q  <= REMW'(rem_n - trial);
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q  <= REMW'(rem_n);
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					if (rcnt_q == '0) begin
						job_q <= JOB_SPREAD;
						st_q  <= ST_DSET;
					end else begin
						rcnt_q <= rcnt_q - 1'b1;
					end
				end
				ST_DSET: begin
					drem_q <= '0;
					dcnt_q <= '0;
					case (job_q)
						JOB_SPREAD: begin
							num_q <= DIV_W'(root_q);
							den_q <= DATA_W'(fill_q);
							st_q  <= ST_DIV;
						end
						JOB_RANGE, JOB_SPR: begin
							den_q <= rmp_bad - rmp_good;
							if (rmp_bad <= rmp_good || rmp_m >= rmp_bad) begin
								num_q <= '0;
								st_q  <= ST_DDONE;
							end else if (rmp_m <= rmp_good) begin
								num_q <= DIV_W'(ONE_Q16);
								st_q  <= ST_DDONE;
							end else begin
								num_q <= {rmp_bad - rmp_m, 16'h0};
								st_q  <= ST_DIV;
							end
						end
						JOB_RATIO: begin
							warm_q <= (vrun_q < WARM16) || unstable_q;
							st_q   <= ST_DIV;
							if ((vrun_q < WARM16) || unstable_q) begin
								num_q <= {vrun_q, 16'h0};
								den_q <= WARM16;
							end else begin
								num_q <= {vrun_q - WARM16, 16'h0};
								den_q <= FULL16;
							end
						end
						default: st_q <= ST_DDONE;
					endcase
				end
				ST_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (dr_n >= {1'b0, den_q}) begin
						drem_q <= DATA_W'(dr_n - {1'b0, den_q});
						num_q  <= {num_q[DIV_W-2:0], 1'b1};
					end else begin
						drem_q <= dr_n[DATA_W-1:0];
						num_q  <= {num_q[DIV_W-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 5'd31) st_q <= ST_DDONE;
				end
				ST_DDONE: begin
					case (job_q)
						JOB_SPREAD: begin
							spread_q <= num_q[DATA_W-1:0];
							job_q    <= JOB_RANGE;
							st_q     <= ST_DSET;
						end
						JOB_RANGE: begin
							s1_q  <= num_q[Q16_W-1:0];
							job_q <= JOB_SPR;
							st_q  <= ST_DSET;
						end
						JOB_SPR: begin
							s2_q  <= num_q[Q16_W-1:0];
							job_q <= JOB_RATIO;
							st_q  <= ST_DSET;
							// unstable latch with calm-run release
							if (high) begin
								unstable_q <= 1'b1;
								calm_q     <= '0;
							end else if (unstable_q) begin
								if (range_q <= cfg_q[REG_CALM_RANGE]) begin
									if (calm_n >= CALM8) begin
										unstable_q <= 1'b0;
										calm_q     <= '0;
									end else begin
										calm_q <= calm_n;
									end
								end else begin
									calm_q <= '0;
								end
							end
						end
						JOB_RATIO: begin
							blend_q <= blend_sum[Q16_W:1];
							st_q    <= ST_BAND;
						end
						default: st_q <= ST_BAND;
					endcase
				end
				ST_BAND: begin
					bprod_q <= 33'(band_diff) * 33'(blend_q);
					st_q    <= ST_FIN;
				end
				ST_FIN: begin
					if (!ovalid_q || score.ready) begin
						ovalid_q <= 1'b1;
						st_q     <= ST_IDLE;
						if (disc_q) begin
							ook_q  <= 1'b0;
							oq_q   <= '0;
							orsn_q <= REASON_DISC;
							orng_q <= '0;
							ospr_q <= '0;
						end else begin
							ook_q  <= 1'b1;
							oq_q   <= band_up ? band_lo + bprod_q[31:16]
								: band_lo - bprod_q[31:16];
							orsn_q <= !warm_q ? REASON_STABLE :
								(vrun_q < WARM16) ? REASON_WARMING : REASON_UNSTABLE;
							orng_q <= range_q;
							ospr_q <= spread_q;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign score.valid         = ovalid_q;
	assign score.quality_ok    = ook_q;
	assign score.quality       = oq_q;
	assign score.reason        = orsn_q;
	assign score.window_range  = orng_q;
	assign score.window_spread = ospr_q;

endmodule

`default_nettype wire

FILE: hw/rtl/wsqs_chk.sv
// ----------------------------------------------------------------------------
// wsqs_chk
// Port-level checks for the scorer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wsqs_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire        quality_ok,
	input wire [15:0] quality,
	input wire [1:0]  reason,
	input wire [15:0] window_range,
	input wire [15:0] window_spread
);
	import wsqs_pkg::*;

	// one item in flight: no accept right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted an item while busy");

	// disconnected result is all zero
	a_disc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !quality_ok |->
			quality == 16'd0 && reason == REASON_DISC &&
			window_range == 16'd0 && window_spread == 16'd0)
		else $error("disconnected result not cleared");

	// valid quality never reports disconnected
	a_ok_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && quality_ok |-> reason != REASON_DISC)
		else $error("valid quality with disconnected reason");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quality) && $stable(reason))
		else $error("stalled result changed");

endmodule

bind windowed_signal_quality_scorer_unit wsqs_chk u_wsqs_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (meas.valid),
	.in_ready     (meas.ready),
	.out_valid    (score.valid),
	.out_ready    (score.ready),
	.quality_ok   (score.quality_ok),
	.quality      (score.quality),
	.reason       (score.reason),
	.window_range (score.window_range),
	.window_spread(score.window_spread)
);

`default_nettype wire

FILE: dv/windowed_signal_quality_scorer_unit_tb.sv
// ----------------------------------------------------------------------------
// windowed_signal_quality_scorer_unit_tb
// Self-checking bench: drives temperature items with contact flags, predicts
// range, spread, latch and quality per item, and checks every score item.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_signal_quality_scorer_unit_tb;

	import wsqs_pkg::*;

	localparam int unsigned WIN      = 32;
	localparam int unsigned WARMUP   = 64;
	localparam int unsigned FULL     = 256;
	localparam int unsigned CALM_REQ = 8;
	localparam int unsigned TOP      = 65535;
	localparam int unsigned LIMIT    = 3000000;
	localparam int unsigned DRAIN    = 400;

	typedef struct packed {
		logic        quality_ok;
		logic [15:0] quality;
		logic [1:0]  reason;
		logic [15:0] window_range;
		logic [15:0] window_spread;
	} score_t;

	// ------------------------------------------------------------------
	// Score predictor and scoreboard
	// ------------------------------------------------------------------
	class score_board;
		logic [15:0] cfg [CFG_NUM];
		int          ring [WIN];
		int unsigned wslot, fill, vrun, calm_cnt;
		bit          latched;
		score_t      pending_q [$];
		int unsigned mismatches, checked, disc_seen, unstable_seen, stable_seen;

		function new();
			for (int i = 0; i < CFG_NUM; i++)
				cfg[i] = cfg_reset_value(3'(i));
			clear();
		endfunction

		function void clear();
			wslot    = 0;
			fill     = 0;
			vrun     = 0;
			latched  = 0;
			calm_cnt = 0;
		endfunction

		function longint unsigned root(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x)
				b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// zero when bad is not above good; else full score at or below good, zero at or above bad
		function int unsigned ramp(int unsigned m, int unsigned good, int unsigned bad);
			if (bad <= good)
				return 0;
			if (m <= good)
				return 65536;
			if (m >= bad)
				return 0;
			return int'((longint'(bad - m) << 16) / longint'(bad - good));
		endfunction

		function int unsigned frac(int unsigned num, int unsigned den);
			longint unsigned r;
			r = (longint'(num) << 16) / den;
			return (r > 65536) ? 65536 : int'(r);
		endfunction

		// inverted band interpolates down from the low end
		function int unsigned blend_band(int unsigned lo, int unsigned hi, int unsigned bl);
			if (hi >= lo)
				return lo + int'((longint'(hi - lo) * bl) >> 16);
			return lo - int'((longint'(lo - hi) * bl) >> 16);
		endfunction

		function void note_input(logic contact, logic signed [15:0] s);
			score_t          e;
			int              mn, mx, v;
			longint          sum;
			longint unsigned sumsq, asum, var_num;
			int unsigned     rng, spr, stab, s1, s2, bl, q;
			bit              high;

			e = '0;
			if (!contact) begin
				clear();
				disc_seen++;
				pending_q.push_back(e);
				return;
			end
			if (wslot >= WIN)
				wslot = 0;
			ring[wslot] = int'(s);
			wslot = (wslot + 1) % WIN;
			if (fill < WIN)
				fill++;
			if (vrun < 65535)
				vrun++;

			mn = ring[0];
			mx = ring[0];
			sum = 0;
			sumsq = 0;
			for (int i = 0; i < fill; i++) begin
				v = ring[i];
				if (v < mn) mn = v;
				if (v > mx) mx = v;
				sum += v;
				sumsq += longint'(v) * longint'(v);
			end
			rng = mx - mn;
			asum = (sum < 0) ? -sum : sum;
			var_num = longint'(fill) * sumsq - asum * asum;
			spr = int'(root(var_num) / fill);

			s1 = ramp(rng, cfg[REG_RANGE_GOOD], cfg[REG_RANGE_BAD]);
			s2 = ramp(spr, cfg[REG_SPREAD_GOOD], cfg[REG_SPREAD_BAD]);
			stab = (s1 < s2) ? s1 : s2;

			// unstable latch: sets at once, releases after a run of calm ranges
			high = (rng > cfg[REG_RANGE_BAD]) || (spr > cfg[REG_SPREAD_BAD]);
			if (high) begin
				latched  = 1;
				calm_cnt = 0;
			end else if (latched) begin
				if (rng <= cfg[REG_CALM_RANGE]) begin
					calm_cnt = (calm_cnt + 1) & 8'hFF;
					if (calm_cnt >= CALM_REQ) begin
						latched  = 0;
						calm_cnt = 0;
					end
				end else begin
					calm_cnt = 0;
				end
			end

			if (vrun < WARMUP || latched) begin
				bl = (frac(vrun, WARMUP) + stab) >> 1;
				q  = blend_band(cfg[REG_SETTLING_LOW], cfg[REG_SETTLING_HIGH], bl);
				e.reason = (vrun < WARMUP) ? REASON_WARMING : REASON_UNSTABLE;
				if (e.reason == REASON_UNSTABLE) unstable_seen++;
			end else begin
				bl = (stab + frac(vrun - WARMUP, FULL)) >> 1;
				q  = blend_band(cfg[REG_SETTLED_LOW], TOP, bl);
				e.reason = REASON_STABLE;
				stable_seen++;
			end
			e.quality_ok    = 1'b1;
			e.quality       = q[15:0];
			e.window_range  = rng[15:0];
			e.window_spread = spr[15:0];
			pending_q.push_back(e);
		endfunction

		function void check(score_t got);
			score_t e;
			checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected score item %p", got);
				return;
			end
			e = pending_q.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: score mismatch exp ok=%0d q=%0d why=%0d rng=%0d spr=%0d",
						e.quality_ok, e.quality, e.reason, e.window_range, e.window_spread);
					$display("       got ok=%0d q=%0d why=%0d rng=%0d spr=%0d",
						got.quality_ok, got.quality, got.reason, got.window_range,
						got.window_spread);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Clock, reset, channels
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic        pready;

	wsqs_meas_if  meas ();
	wsqs_score_if score ();

	score_board  sb = new();
	int unsigned send_idle_pct, recv_idle_pct;
	int unsigned items_sent;
	longint unsigned cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	windowed_signal_quality_scorer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.meas    (meas.sink),
		.score   (score.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		meas.valid      = 1'b0;
		meas.contact_ok = 1'b0;
		meas.sample     = '0;
		score.ready     = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("ERROR: timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end
	initial cycles = 0;

	// score sink: random stall at the falling edge, check at the rising edge
	always @(negedge clk)
		score.ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && score.valid && score.ready)
			sb.check('{score.quality_ok, score.quality, score.reason,
				score.window_range, score.window_spread});
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// setup cycle then access cycle; the register takes the value at the access edge
	task automatic reg_write(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = PADDR_W'(idx) << 2;
		pwdata  = {16'h0, val};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.cfg[idx] = val;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		// read back
		@(negedge clk);
		psel = 1'b1;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[15:0] !== val) begin
			sb.mismatches++;
			if (sb.mismatches <= 10)
				$display("ERROR: reg %0d readback exp %0d got %0d", idx, val, prdata[15:0]);
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// holds valid across back-to-back items; all changes at the falling edge
	task automatic send(logic contact, logic signed [15:0] s);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			meas.valid = 1'b0;
			meas.contact_ok = 1'($urandom_range(1));
			meas.sample     = 16'($urandom);
			@(negedge clk);
		end
		meas.valid      = 1'b1;
		meas.contact_ok = contact;
		meas.sample     = s;
		@(posedge clk);
		while (!meas.ready) @(posedge clk);
		sb.note_input(contact, s);
		items_sent++;
	endtask

	task automatic go_quiet();
		@(negedge clk);
		meas.valid = 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// connected runs with a noise level picked per run, with disconnect items mixed in
	task automatic random_runs(int unsigned n_items);
		int unsigned done, len, amp, kind;
		int          base, v;
		done = 0;
		while (done < n_items) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				send(1'b0, 16'($urandom));
				done++;
				continue;
			end
			len  = (kind < 30) ? $urandom_range(1, 40) : $urandom_range(60, 260);
			base = $urandom_range(0, 20000) - 10000;
			case ($urandom_range(4))
				0: amp = 0;
				1: amp = $urandom_range(1, 12);
				2: amp = $urandom_range(10, 60);
				3: amp = $urandom_range(50, 300);
				default: amp = 40000;
			endcase
			for (int i = 0; i < len && done < n_items; i++) begin
				if (amp == 40000)
					v = $signed(16'($urandom));
				else if ($urandom_range(99) < 3)
					v = base + $urandom_range(0, 600) - 300;   // spike
				else
					v = base + $urandom_range(0, 2 * amp) - amp;
				send(1'b1, 16'(v));
				done++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		send_idle_pct = 12;
		recv_idle_pct = 77;
		items_sent    = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: disconnect, field extremes, flat window, big swing
		send(1'b0, 16'sh7FFF);
		send(1'b1, 16'sh7FFF);
		send(1'b1, -16'sh8000);
		send(1'b1, 16'sh0000);
		send(1'b1, 16'shFFFF);
		send(1'b0, -16'sh8000);
		for (int i = 0; i < 12; i++)
			send(1'b1, 16'sd100 + 16'(i & 1));
		send(1'b1, 16'sd400);          // range high, latch sets
		for (int i = 0; i < 4; i++)
			send(1'b1, 16'sd100);
		send(1'b0, 16'sd0);
		go_quiet();

		// phase 1: defaults, sender light idle, receiver heavy stall
		random_runs(340);
		go_quiet();

		// phase 2: extremes, inverted settling band
		send_idle_pct = 77;
		recv_idle_pct = 12;
		reg_write(REG_RANGE_GOOD, 16'd0);
		reg_write(REG_RANGE_BAD, 16'hFFFF);
		reg_write(REG_SPREAD_GOOD, 16'd0);
		reg_write(REG_SPREAD_BAD, 16'hFFFF);
		reg_write(REG_CALM_RANGE, 16'd0);
		reg_write(REG_SETTLING_LOW, 16'hFFFF);
		reg_write(REG_SETTLING_HIGH, 16'd0);
		reg_write(REG_SETTLED_LOW, 16'd0);
		random_runs(340);
		go_quiet();

		// phase 3: bad not above good, no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		reg_write(REG_RANGE_GOOD, 16'hFFFF);
		reg_write(REG_RANGE_BAD, 16'd30);
		reg_write(REG_SPREAD_GOOD, 16'd20);
		reg_write(REG_SPREAD_BAD, 16'd20);
		reg_write(REG_CALM_RANGE, 16'hFFFF);
		reg_write(REG_SETTLING_LOW, 16'd0);
		reg_write(REG_SETTLING_HIGH, 16'hFFFF);
		reg_write(REG_SETTLED_LOW, 16'hFFFF);
		random_runs(340);
		go_quiet();

		// phase 4: random mid-range thresholds
		reg_write(REG_RANGE_GOOD, 16'($urandom_range(0, 80)));
		reg_write(REG_RANGE_BAD, 16'($urandom_range(60, 400)));
		reg_write(REG_SPREAD_GOOD, 16'($urandom_range(0, 40)));
		reg_write(REG_SPREAD_BAD, 16'($urandom_range(20, 150)));
		reg_write(REG_CALM_RANGE, 16'($urandom_range(20, 300)));
		reg_write(REG_SETTLING_LOW, 16'($urandom));
		reg_write(REG_SETTLING_HIGH, 16'($urandom));
		reg_write(REG_SETTLED_LOW, 16'($urandom));
		random_runs(410);

		@(negedge clk);
		meas.valid = 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Run: %0d items sent, %0d score items checked", items_sent, sb.checked);
		$display("Seen: %0d disconnects, %0d unstable, %0d stable; 4 register settings",
			sb.disc_seen, sb.unstable_seen, sb.stable_seen);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("ERROR: %0d mismatches, %0d items never came out",
				sb.mismatches, sb.pending_q.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
